[hw/rtl/uart_line_editor_macros.svh]
// Assertion helpers for the line editor
`ifndef UART_LINE_EDITOR_MACROS_SVH
`define UART_LINE_EDITOR_MACROS_SVH

`ifndef SYNTHESIS

`define ULE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ULE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ULE_ASSERT_SAME(lbl, ante, cons)
`define ULE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/ule_pkg.sv]
`timescale 1ns / 1ps

package ule_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int FILL_W     = ADDR_W;
  localparam int LEN_W      = 5;
  localparam int BYTE_W     = 8;
  localparam int TDATA_W    = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_OVF   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ECHO,
    OP_BS,
    OP_CR,
    OP_OVF
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PRE,
    BK_READ,
    BK_LINE,
    BK_TAIL
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic              echo;
    logic [FILL_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [1:0] pre_len(op_t op, logic echo);
    logic [1:0] n;
    unique case (op)
      OP_ECHO: n = 2'd1;
      OP_BS:   n = 2'd3;
      OP_CR:   n = echo ? 2'd3 : 2'd0;
      OP_OVF:  n = echo ? 2'd3 : 2'd0;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pre_char(op_t op, logic [1:0] step, logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (op == OP_BS) begin
      c = (step == 2'd1) ? CH_SP : CH_BS;
    end else if (step == 2'd0) begin
      c = (op == OP_CR) ? CH_CR : b;
    end else if (step == 2'd1) begin
      c = CH_LF;
    end else begin
      c = CH_CR;
    end
    return c;
  endfunction

endpackage

[hw/rtl/ule_ram.sv]
`timescale 1ns / 1ps

module ule_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/ule_front.sv]
`timescale 1ns / 1ps

module ule_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,
  input  ule_pkg::q_stat_t           q_stat,
  output logic                       push,
  output ule_pkg::cmd_t              push_cmd,
  input  logic                       line_done,
  output logic                       ram_we,
  output logic [ule_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata
);
  import ule_pkg::*;

  logic              echo;
  logic              busy;
  logic              busy_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W:0]   fill_inc;
  logic              accept;

  assign s_tready  = !busy && !q_stat.full;
  assign accept    = s_tvalid && s_tready;
  assign fill_inc  = {1'b0, fill} + 1'b1;
  assign ram_waddr = ADDR_W'(fill);
  assign ram_wdata = s_tdata;

  always_comb begin
    push          = 1'b0;
    push_cmd.op   = OP_ECHO;
    push_cmd.data = s_tdata;
    push_cmd.echo = echo;
    push_cmd.len  = fill;
    ram_we        = 1'b0;
    fill_next     = fill;
    busy_next     = busy && !line_done;
    if (accept) begin
      if (echo && (s_tdata == CH_BS || s_tdata == CH_DEL)) begin
        push        = 1'b1;
        push_cmd.op = OP_BS;
        if (fill != '0) begin
          fill_next = fill - 1'b1;
        end
      end else if (s_tdata == CH_CR) begin
        push        = 1'b1;
        push_cmd.op = OP_CR;
        fill_next   = '0;
        busy_next   = 1'b1;
      end else begin
        ram_we = 1'b1;
        if (fill_inc >= (FILL_W+1)'(LINE_DEPTH - 1)) begin
          push        = 1'b1;
          push_cmd.op = OP_OVF;
          fill_next   = '0;
        end else begin
          push      = echo;
          fill_next = fill_inc[FILL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo <= 1'b0;
      busy <= 1'b0;
      fill <= '0;
    end else begin
      if (cfg_wr_en) begin
        echo <= cfg_wr_data;
      end
      busy <= busy_next;
      fill <= fill_next;
    end
  end

endmodule

[hw/rtl/ule_queue.sv]
`timescale 1ns / 1ps

module ule_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ule_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output ule_pkg::cmd_t     head,
  output ule_pkg::q_stat_t  q_stat
);
  import ule_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/ule_back.sv]
`timescale 1ns / 1ps

module ule_back (
  input  logic                       clk,
  input  logic                       rst,
  input  ule_pkg::q_stat_t           q_stat,
  input  ule_pkg::cmd_t              head,
  output logic                       pop,
  output logic                       line_done,
  output logic                       ram_re,
  output logic [ule_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [7:0]                 ram_rdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,
  output logic [1:0]                 m_tuser,
  output logic                       m_tlast
);
  import ule_pkg::*;

  bk_state_t         state;
  bk_state_t         state_next;
  cmd_t              cmd;
  cmd_t              cmd_next;
  logic [1:0]        step;
  logic [1:0]        step_next;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] idx_next;
  logic              out_free;
  logic              emit;
  kind_t             e_kind;
  logic [7:0]        e_data;
  logic [LEN_W-1:0]  e_len;
  logic              e_last;
  logic [1:0]        plen;
  bk_state_t         after_pre;

  assign out_free  = !m_tvalid || m_tready;
  assign plen      = pre_len(cmd.op, cmd.echo);
  assign after_pre = (cmd.op == OP_CR && cmd.len != '0) ? BK_READ : BK_TAIL;

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    step_next  = step;
    idx_next   = idx;
    pop        = 1'b0;
    line_done  = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx;
    emit       = 1'b0;
    e_kind     = KIND_ECHO;
    e_data     = '0;
    e_len      = '0;
    e_last     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cmd_next  = head;
          step_next = '0;
          idx_next  = '0;
          if (pre_len(head.op, head.echo) != 2'd0) begin
            state_next = BK_PRE;
          end else if (head.op == OP_CR && head.len != '0) begin
            state_next = BK_READ;
          end else begin
            state_next = BK_TAIL;
          end
        end
      end
      BK_PRE: begin
        e_kind = KIND_ECHO;
        e_data = pre_char(cmd.op, step, cmd.data);
        e_last = (step == plen - 2'd1) && (cmd.op == OP_BS || cmd.op == OP_ECHO);
        if (out_free) begin
          emit = 1'b1;
          if (step == plen - 2'd1) begin
            if (cmd.op == OP_BS || cmd.op == OP_ECHO) begin
              state_next = BK_IDLE;
            end else begin
              state_next = after_pre;
            end
          end else begin
            step_next = step + 2'd1;
          end
        end
      end
      BK_READ: begin
        ram_re     = 1'b1;
        state_next = BK_LINE;
      end
      BK_LINE: begin
        e_kind = KIND_LINE;
        e_data = ram_rdata;
        e_len  = LEN_W'(cmd.len);
        e_last = (idx == ADDR_W'(cmd.len - 1'b1));
        if (out_free) begin
          emit     = 1'b1;
          idx_next = idx + 1'b1;
          if (e_last) begin
            line_done  = 1'b1;
            state_next = BK_IDLE;
          end else begin
            state_next = BK_READ;
          end
        end
      end
      BK_TAIL: begin
        e_kind = (cmd.op == OP_CR) ? KIND_EMPTY : KIND_OVF;
        e_last = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          line_done  = (cmd.op == OP_CR);
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd  <= cmd_next;
    step <= step_next;
    idx  <= idx_next;
    if (emit) begin
      m_tdata <= {{(TDATA_W - BYTE_W - LEN_W){1'b0}}, e_len, e_data};
      m_tuser <= e_kind;
      m_tlast <= e_last;
    end
  end

endmodule

[hw/rtl/uart_line_editor.sv]
`timescale 1ns / 1ps
// Console line editor.
// Input stream s_*: one received byte per word. Output stream m_*: echo words
// for the transmitter (kind echo), then the line words for the command decoder
// (kind line, tlast on the final one), a single empty-line word, or an
// overflow word. tlast marks the final word caused by each received byte.
// cfg_wr_en/cfg_wr_data set echo_enable; write it only while the block is idle.
// The first word of a received byte passes through the command queue and the
// back end's command register before it is loaded into the output register.
// The echo words of a byte leave at one per cycle while the output is free; each
// line word waits for its byte to be read from the line store (registered read
// port) before it is sent. Plain bytes are taken one per cycle while the
// two-entry command queue has room; after a carriage return no byte is taken
// until the last line word or the empty-line word has been loaded into the
// output register.
// Reset: echo off, fill count zero, queue empty, no output word pending; the
// line store is not cleared. A stalled receiver holds the output register,
// the back end waits, the queue fills and s_tready drops.
module uart_line_editor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // echo_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // [7:0] data_byte, [12:8] line_length, rest zero
  output logic [1:0]  m_tuser,      // [1:0] kind
  output logic        m_tlast       // last
);
  import ule_pkg::*;

`include "uart_line_editor_macros.svh"

  q_stat_t           q_stat;
  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  cmd_t              head;
  logic              line_done;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  ule_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .q_stat      (q_stat),
    .push        (push),
    .push_cmd    (push_cmd),
    .line_done   (line_done),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  ule_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  ule_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ule_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .line_done (line_done),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  `ULE_ASSERT_NEXT(a_cr_blocks_input, s_tvalid && s_tready && s_tdata == CH_CR, !s_tready)
  `ULE_ASSERT_SAME(a_line_has_length, m_tvalid && m_tuser == KIND_LINE, m_tdata[12:8] != 5'd0)
  `ULE_ASSERT_SAME(a_tail_is_last, m_tvalid && (m_tuser == KIND_EMPTY || m_tuser == KIND_OVF), m_tlast && m_tdata == 16'd0)
  `ULE_ASSERT_SAME(a_no_push_when_full, push, !q_stat.full || pop)

endmodule
